>>> src/zmat_pkg.sv
package zmat_pkg;

  // Field widths, fixed by the command and result formats
  localparam int CMD_W  = 3;
  localparam int IDX_W  = 4;
  localparam int WORD_W = 32;
  localparam int STAT_W = 3;

  // Default table depth and the cap on results of one dump
  localparam int ENTRIES_DEF = 16;
  localparam int MAXRES      = 16;

  // Depth of the request queue between front and back
  localparam int QDEPTH = 2;

  // Command codes as they arrive
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  // Classified operation, as the front hands it to the back
  typedef enum logic [2:0] {
    OP_SEARCH,
    OP_MODIFY,
    OP_INSERT,
    OP_REMOVE,
    OP_DUMP,
    OP_RANGE
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] val;
  } req_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MOD,
    ST_REPLY,
    ST_DFIN
  } state_t;

endpackage

>>> src/zmat_front.sv
module zmat_front #(
  parameter int ENTRIES = zmat_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [zmat_pkg::CMD_W-1:0]        in_command,
  input  logic [zmat_pkg::IDX_W-1:0]        in_index,
  input  logic signed [zmat_pkg::WORD_W-1:0] in_value,
  output logic                              q_vld,
  output zmat_pkg::req_t                    q_req,
  input  logic                              q_pop
);
  import zmat_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW  = $clog2(QDEPTH + 1);

  req_t           q_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  req_t           cls;
  logic           keep;
  logic           push;
  logic           range_err;

  // Classify the incoming request; unknown codes are dropped
  always_comb begin
    range_err = (32'(in_index) >= 32'(ENTRIES));
    cls.idx   = in_index;
    cls.val   = in_value;
    cls.op    = OP_SEARCH;
    keep      = 1'b1;
    unique case (in_command)
      CMD_SEARCH: cls.op = OP_SEARCH;
      CMD_MODIFY: cls.op = range_err ? OP_RANGE : OP_MODIFY;
      CMD_INSERT: cls.op = OP_INSERT;
      CMD_REMOVE: cls.op = range_err ? OP_RANGE : OP_REMOVE;
      CMD_DUMP:   cls.op = OP_DUMP;
      default:    keep   = 1'b0;
    endcase
  end

  assign in_stall = (cnt_r == CW'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_vld    = (cnt_r != '0);
  assign q_req    = q_r[rp_r];

  // Queue pointers and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QAW'(QDEPTH - 1)) ? '0 : wp_r + QAW'(1);
    end
    if (q_pop) begin
      rp_nxt = (rp_r == QAW'(QDEPTH - 1)) ? '0 : rp_r + QAW'(1);
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

>>> src/zmat_back.sv
module zmat_back #(
  parameter int ENTRIES = zmat_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_vld,
  input  zmat_pkg::req_t                     q_req,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [zmat_pkg::STAT_W-1:0]        out_status,
  output logic [zmat_pkg::IDX_W-1:0]         out_position,
  output logic signed [zmat_pkg::WORD_W-1:0] out_old_value,
  output logic signed [zmat_pkg::WORD_W-1:0] out_element,
  output logic                               out_last
);
  import zmat_pkg::*;

  localparam int AW     = $clog2(ENTRIES);
  localparam int DUMP_N = (ENTRIES < MAXRES) ? ENTRIES : MAXRES;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [AW-1:0] DUMP_LAST = AW'(DUMP_N - 1);

  // Table memory, valid bits stand in for the reset to zero
  logic signed [WORD_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]       vld_r;
  logic signed [WORD_W-1:0] rd_r;
  logic                     rd_vld_r;

  state_t                   st_r, st_nxt;
  req_t                     req_r, req_nxt;
  logic [AW-1:0]            rptr_r, rptr_nxt;
  logic                     issued_r, issued_nxt;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            paddr_r, paddr_nxt;
  logic                     hit_r, hit_nxt;
  logic [AW-1:0]            at_r, at_nxt;
  logic                     hold_vld_r, hold_vld_nxt;
  logic signed [WORD_W-1:0] hold_word_r, hold_word_nxt;
  logic [AW-1:0]            hold_pos_r, hold_pos_nxt;
  logic [STAT_W-1:0]        rs_status_r, rs_status_nxt;
  logic [IDX_W-1:0]         rs_pos_r, rs_pos_nxt;
  logic signed [WORD_W-1:0] rs_elem_r, rs_elem_nxt;

  logic                     re, we, clr_last;
  logic [AW-1:0]            ra, wa;
  logic signed [WORD_W-1:0] wd;

  logic                     emit;
  logic [STAT_W-1:0]        e_status;
  logic [IDX_W-1:0]         e_pos;
  logic signed [WORD_W-1:0] e_old, e_elem;
  logic                     e_last;

  logic                     out_vld_r;
  logic                     out_free;
  logic signed [WORD_W-1:0] word;
  logic [AW-1:0]            wlast;
  logic                     need_emit;
  logic                     proceed;
  logic                     match;

  assign out_free  = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign word      = rd_vld_r ? rd_r : '0;
  assign match     = (word == req_r.val);
  assign wlast     = (req_r.op == OP_DUMP) ? DUMP_LAST : LAST_ADDR;
  assign need_emit = pend_r && (req_r.op == OP_DUMP) && ((word == '0) || hold_vld_r);
  assign proceed   = !need_emit || out_free;

  // Sequencer: next state, memory control and result emit
  always_comb begin
    st_nxt        = st_r;
    req_nxt       = req_r;
    rptr_nxt      = rptr_r;
    issued_nxt    = issued_r;
    pend_nxt      = pend_r;
    paddr_nxt     = paddr_r;
    hit_nxt       = hit_r;
    at_nxt        = at_r;
    hold_vld_nxt  = hold_vld_r;
    hold_word_nxt = hold_word_r;
    hold_pos_nxt  = hold_pos_r;
    rs_status_nxt = rs_status_r;
    rs_pos_nxt    = rs_pos_r;
    rs_elem_nxt   = rs_elem_r;
    q_pop         = 1'b0;
    re            = 1'b0;
    ra            = rptr_r;
    we            = 1'b0;
    wa            = paddr_r;
    wd            = word;
    clr_last      = 1'b0;
    emit          = 1'b0;
    e_status      = STAT_OK;
    e_pos         = '0;
    e_old         = '0;
    e_elem        = '0;
    e_last        = 1'b1;

    unique case (st_r)
      ST_IDLE: begin
        if (q_vld) begin
          unique case (q_req.op)
            OP_RANGE: begin
              if (out_free) begin
                q_pop    = 1'b1;
                emit     = 1'b1;
                e_status = STAT_RANGE;
                e_pos    = q_req.idx;
              end
            end
            OP_MODIFY: begin
              q_pop   = 1'b1;
              req_nxt = q_req;
              re      = 1'b1;
              ra      = AW'(q_req.idx);
              st_nxt  = ST_MOD;
            end
            OP_REMOVE: begin
              q_pop         = 1'b1;
              req_nxt       = q_req;
              rs_status_nxt = STAT_OK;
              rs_pos_nxt    = q_req.idx;
              rs_elem_nxt   = '0;
              issued_nxt    = 1'b0;
              pend_nxt      = 1'b0;
              if (32'(q_req.idx) == 32'(ENTRIES - 1)) begin
                // removing the top slot only empties it
                clr_last = 1'b1;
                st_nxt   = ST_REPLY;
              end else begin
                rptr_nxt = AW'(32'(q_req.idx) + 32'd1);
                st_nxt   = ST_WALK;
              end
            end
            default: begin
              q_pop        = 1'b1;
              req_nxt      = q_req;
              rptr_nxt     = '0;
              issued_nxt   = 1'b0;
              pend_nxt     = 1'b0;
              hit_nxt      = 1'b0;
              hold_vld_nxt = 1'b0;
              st_nxt       = ST_WALK;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (proceed) begin
          // one read issued per cycle while the walk proceeds; the registered data is compared next
          if (!issued_r) begin
            re         = 1'b1;
            ra         = rptr_r;
            rptr_nxt   = rptr_r + AW'(1);
            issued_nxt = (rptr_r == wlast);
            pend_nxt   = 1'b1;
            paddr_nxt  = rptr_r;
          end else begin
            pend_nxt = 1'b0;
          end
          if (pend_r) begin
            unique case (req_r.op)
              OP_SEARCH: begin
                if (match) begin
                  hit_nxt = 1'b1;
                  at_nxt  = paddr_r;
                end
                if (paddr_r == LAST_ADDR) begin
                  st_nxt        = ST_REPLY;
                  rs_status_nxt = (hit_r || match) ? STAT_OK : STAT_NOTFOUND;
                  rs_pos_nxt    = match ? IDX_W'(paddr_r) :
                                  (hit_r ? IDX_W'(at_r) : '0);
                  rs_elem_nxt   = (hit_r || match) ? req_r.val : '0;
                end
              end
              OP_INSERT: begin
                if (word == '0) begin
                  we            = 1'b1;
                  wa            = paddr_r;
                  wd            = req_r.val;
                  st_nxt        = ST_REPLY;
                  rs_status_nxt = STAT_OK;
                  rs_pos_nxt    = IDX_W'(paddr_r);
                  rs_elem_nxt   = req_r.val;
                end else if (paddr_r == LAST_ADDR) begin
                  st_nxt        = ST_REPLY;
                  rs_status_nxt = STAT_FULL;
                  rs_pos_nxt    = '0;
                  rs_elem_nxt   = '0;
                end
              end
              OP_REMOVE: begin
                // shift this slot down by one
                we = 1'b1;
                wa = paddr_r - AW'(1);
                wd = word;
                if (32'(paddr_r) == 32'(req_r.idx) + 32'd1) begin
                  rs_elem_nxt = word;
                end
                if (paddr_r == LAST_ADDR) begin
                  clr_last = 1'b1;
                  st_nxt   = ST_REPLY;
                end
              end
              OP_DUMP: begin
                if (word == '0) begin
                  emit   = 1'b1;
                  e_last = 1'b1;
                  if (hold_vld_r) begin
                    e_status = STAT_OK;
                    e_pos    = IDX_W'(hold_pos_r);
                    e_elem   = hold_word_r;
                  end else begin
                    e_status = STAT_EMPTY;
                  end
                  st_nxt = ST_IDLE;
                end else begin
                  // the held word goes out once its successor is known
                  if (hold_vld_r) begin
                    emit     = 1'b1;
                    e_status = STAT_OK;
                    e_pos    = IDX_W'(hold_pos_r);
                    e_elem   = hold_word_r;
                    e_last   = 1'b0;
                  end
                  hold_vld_nxt  = 1'b1;
                  hold_word_nxt = word;
                  hold_pos_nxt  = paddr_r;
                  if (paddr_r == DUMP_LAST) begin
                    st_nxt = ST_DFIN;
                  end
                end
              end
              default: begin
                st_nxt = ST_IDLE;
              end
            endcase
          end
        end
      end

      ST_MOD: begin
        if (out_free) begin
          we       = 1'b1;
          wa       = AW'(req_r.idx);
          wd       = req_r.val;
          emit     = 1'b1;
          e_status = STAT_OK;
          e_pos    = req_r.idx;
          e_old    = word;
          e_elem   = req_r.val;
          st_nxt   = ST_IDLE;
        end
      end

      ST_REPLY: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = rs_status_r;
          e_pos    = rs_pos_r;
          e_elem   = rs_elem_r;
          st_nxt   = ST_IDLE;
        end
      end

      ST_DFIN: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = STAT_OK;
          e_pos    = IDX_W'(hold_pos_r);
          e_elem   = hold_word_r;
          e_last   = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      issued_r   <= 1'b0;
      pend_r     <= 1'b0;
      hit_r      <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      issued_r   <= issued_nxt;
      pend_r     <= pend_nxt;
      hit_r      <= hit_nxt;
      hold_vld_r <= hold_vld_nxt;
      if (out_free) begin
        out_vld_r <= emit;
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    rptr_r      <= rptr_nxt;
    paddr_r     <= paddr_nxt;
    at_r        <= at_nxt;
    hold_word_r <= hold_word_nxt;
    hold_pos_r  <= hold_pos_nxt;
    rs_status_r <= rs_status_nxt;
    rs_pos_r    <= rs_pos_nxt;
    rs_elem_r   <= rs_elem_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      out_status    <= e_status;
      out_position  <= e_pos;
      out_old_value <= e_old;
      out_element   <= e_elem;
      out_last      <= e_last;
    end
  end

  // Slot valid bits: cleared at reset, set on write, top slot cleared by remove
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      if (clr_last) begin
        vld_r[LAST_ADDR] <= 1'b0;
      end
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r     <= mem[ra];
      rd_vld_r <= vld_r[ra];
    end
  end

endmodule

>>> src/zero_marked_array_table.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_command, in_index, in_value
// out      output     out_valid/out_stall out_status, out_position, out_old_value,
//                                         out_element, out_last
//
// Search, insert and remove walk the table through its single read port, one
// slot per cycle. Dump reads at most min(ENTRIES, 16) slots.
// Reset clears the slot valid bits; no clearing pass is needed.
// A two-entry queue parts the front from the walking back end; a stall on the
// output holds a dump walk and any reply, and the input stalls only when that
// queue is full.
module zero_marked_array_table #(
  parameter int ENTRIES = zmat_pkg::ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [zmat_pkg::CMD_W-1:0]         in_command,
  input  logic [zmat_pkg::IDX_W-1:0]         in_index,
  input  logic signed [zmat_pkg::WORD_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [zmat_pkg::STAT_W-1:0]        out_status,
  output logic [zmat_pkg::IDX_W-1:0]         out_position,
  output logic signed [zmat_pkg::WORD_W-1:0] out_old_value,
  output logic signed [zmat_pkg::WORD_W-1:0] out_element,
  output logic                               out_last
);
  import zmat_pkg::*;

  logic q_vld;
  req_t q_req;
  logic q_pop;

  // Front: accept, classify and queue requests
  zmat_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_index   (in_index),
    .in_value   (in_value),
    .q_vld      (q_vld),
    .q_req      (q_req),
    .q_pop      (q_pop)
  );

  // Back: table memory and walking sequencer
  zmat_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_vld         (q_vld),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_position  (out_position),
    .out_old_value (out_old_value),
    .out_element   (out_element),
    .out_last      (out_last)
  );

  // The back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld)
    else $error("request queue popped while empty");

  // Requests other than dump give exactly one result, so an error result carries last
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_last)
    else $error("error status result without last flag");

  // An empty dump reports nothing but its status
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |->
      (out_position == '0) && (out_element == '0) && (out_old_value == '0))
    else $error("empty dump result carries data");

  // No result comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

>>> tb/zero_marked_array_table_test.sv
module zero_marked_array_table_test;
  import zmat_pkg::*;

  localparam int TABLE_DEPTH   = ENTRIES_DEF;
  localparam int N_RANDOM      = 380;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;

  // codes the block decodes as no operation
  localparam logic [CMD_W-1:0] CMD_NOP_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NOP_LAST  = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         idx;
    logic signed [WORD_W-1:0] val;
    bit                       hold_off;  // wait for all replies before sending
  } request_t;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic [IDX_W-1:0]         position;
    logic signed [WORD_W-1:0] old_value;
    logic signed [WORD_W-1:0] element;
    logic                     last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = '0;
  logic [IDX_W-1:0]         in_index = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic [IDX_W-1:0]         out_position;
  logic signed [WORD_W-1:0] out_old_value;
  logic signed [WORD_W-1:0] out_element;
  logic                     out_last;

  zero_marked_array_table uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_index     (in_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_position (out_position),
    .out_old_value(out_old_value),
    .out_element  (out_element),
    .out_last     (out_last)
  );

  always #10 clk = ~clk;

  request_t                 pending_q[$];
  reply_t                   reply_q[$];
  logic signed [WORD_W-1:0] table_shadow[TABLE_DEPTH];
  logic signed [WORD_W-1:0] used_vals[$];

  int n_accepted = 0;
  int n_replies  = 0;
  int n_mismatch = 0;

  // Table predictor: updates the shadow table and queues the replies
  function automatic void apply_command(input request_t rq);
    int     hit_at;
    int     fill;
    reply_t rp;
    rp.status    = STAT_OK;
    rp.position  = '0;
    rp.old_value = '0;
    rp.element   = '0;
    rp.last      = 1'b1;
    case (rq.cmd)
      CMD_SEARCH: begin
        hit_at = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (table_shadow[i] == rq.val) hit_at = i;
        if (hit_at < 0) begin
          rp.status = STAT_NOTFOUND;
        end else begin
          rp.position = IDX_W'(hit_at);
          rp.element  = rq.val;
        end
        reply_q.push_back(rp);
      end
      CMD_MODIFY: begin
        rp.position = rq.idx;
        if (rq.idx >= TABLE_DEPTH) begin
          rp.status = STAT_RANGE;
        end else begin
          rp.old_value = table_shadow[rq.idx];
          table_shadow[rq.idx] = rq.val;
          rp.element = rq.val;
        end
        reply_q.push_back(rp);
      end
      CMD_INSERT: begin
        fill = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (fill < 0 && table_shadow[i] == 0) fill = i;
        if (fill < 0) begin
          rp.status = STAT_FULL;
        end else begin
          table_shadow[fill] = rq.val;
          rp.position = IDX_W'(fill);
          rp.element  = rq.val;
        end
        reply_q.push_back(rp);
      end
      CMD_REMOVE: begin
        rp.position = rq.idx;
        if (rq.idx >= TABLE_DEPTH) begin
          rp.status = STAT_RANGE;
        end else begin
          for (int i = rq.idx; i < TABLE_DEPTH - 1; i++)
            table_shadow[i] = table_shadow[i + 1];
          table_shadow[TABLE_DEPTH - 1] = '0;
          rp.element = table_shadow[rq.idx];
        end
        reply_q.push_back(rp);
      end
      CMD_DUMP: begin
        fill = 0;
        while (fill < TABLE_DEPTH && table_shadow[fill] != 0) fill++;
        if (fill == 0) begin
          rp.status = STAT_EMPTY;
          reply_q.push_back(rp);
        end else begin
          if (fill > MAXRES) fill = MAXRES;
          for (int i = 0; i < fill; i++) begin
            rp.position = IDX_W'(i);
            rp.element  = table_shadow[i];
            rp.last     = (i == fill - 1);
            reply_q.push_back(rp);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic signed [WORD_W-1:0] val, input bit hold_off = 1'b0);
    request_t rq;
    rq.cmd      = cmd;
    rq.idx      = idx;
    rq.val      = val;
    rq.hold_off = hold_off;
    pending_q.push_back(rq);
    if (cmd == CMD_INSERT || cmd == CMD_MODIFY) used_vals.push_back(val);
  endtask

  // Mix of zero, extremes, repeats of insert and modify values, small and full-range words
  function automatic logic signed [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 2) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    if (r <= 6 && used_vals.size() != 0)
      return used_vals[$urandom_range(0, used_vals.size() - 1)];
    if (r <= 10) return $urandom_range(1, 20);
    return $urandom;
  endfunction

  // Driver: one request at a time, random gap after each accepted request
  request_t cur_req;
  bit       has_item = 1'b0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      has_item = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(cur_req);
        n_accepted++;
        has_item = 1'b0;
        gap_left = ((n_accepted / 50) % 4 == 2) ? 0 : $urandom_range(0, 10);
      end
      if (!has_item && gap_left == 0 && pending_q.size() != 0 &&
          !(pending_q[0].hold_off && reply_q.size() != 0)) begin
        cur_req = pending_q.pop_front();
        has_item = 1'b1;
        in_valid   <= 1'b1;
        in_command <= cur_req.cmd;
        in_index   <= cur_req.idx;
        in_value   <= cur_req.val;
      end else if (!has_item) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: random stall after each reply, compare against oldest prediction
  int     stall_left = 0;
  reply_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_replies++;
        if (reply_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS)
            $display("unexpected reply: status %0d pos %0d old %0d elem %0d last %0b",
                     out_status, out_position, out_old_value, out_element, out_last);
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status || out_position !== want.position ||
              out_old_value !== want.old_value || out_element !== want.element ||
              out_last !== want.last) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
              $display("reply %0d mismatch", n_replies);
              $display("  expected: status %0d pos %0d old %0d elem %0d last %0b",
                       want.status, want.position, want.old_value, want.element, want.last);
              $display("  actual:   status %0d pos %0d old %0d elem %0d last %0b",
                       out_status, out_position, out_old_value, out_element, out_last);
            end
          end
        end
        stall_left = ((n_replies / 60) % 3 == 1) ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n_cmds;
    int phase;
    int r;
    int t_ins, t_srch, t_mod, t_rem;
    logic signed [WORD_W-1:0] v;

    for (int i = 0; i < TABLE_DEPTH; i++) table_shadow[i] = '0;

    // directed: empty table, extremes, holes, shifts, dead codes
    add_request(CMD_DUMP,   4'd0,  $urandom);
    add_request(CMD_SEARCH, 4'd0,  32'sd0);
    add_request(CMD_SEARCH, 4'd9,  32'sd5);
    add_request(CMD_REMOVE, 4'd3,  $urandom);
    add_request(CMD_INSERT, 4'd15, 32'sh7fff_ffff);
    add_request(CMD_INSERT, 4'd0,  32'sh8000_0000);
    add_request(CMD_INSERT, 4'd7,  -32'sd1);
    add_request(CMD_INSERT, 4'd2,  32'sd1);
    add_request(CMD_INSERT, 4'd5,  32'sd0);
    add_request(CMD_MODIFY, 4'd15, 32'sh8000_0000);
    add_request(CMD_SEARCH, 4'd0,  32'sh8000_0000);
    add_request(CMD_DUMP,   4'd15, $urandom);
    add_request(CMD_MODIFY, 4'd1,  32'sd0);
    add_request(CMD_DUMP,   4'd0,  $urandom);
    add_request(CMD_INSERT, 4'd0,  32'sd7);
    add_request(CMD_REMOVE, 4'd0,  $urandom);
    add_request(CMD_REMOVE, 4'd15, $urandom);
    add_request(CMD_MODIFY, 4'd0,  32'sd0);
    add_request(CMD_DUMP,   4'd0,  $urandom);
    for (int c = CMD_NOP_FIRST; c <= CMD_NOP_LAST; c++)
      add_request(CMD_W'(c), 4'($urandom), $urandom);
    add_request(CMD_SEARCH, 4'd3,  -32'sd1, 1'b1);
    add_request(CMD_MODIFY, 4'd14, 32'sd12345);

    // random: alternate fill, mixed and drain phases
    n_cmds = 0;
    while (n_cmds < N_RANDOM) begin
      phase = (n_cmds / 40) % 3;
      case (phase)
        0:       begin t_ins = 60; t_srch = 75; t_mod = 85; t_rem = 90; end
        1:       begin t_ins = 25; t_srch = 50; t_mod = 65; t_rem = 85; end
        default: begin t_ins = 10; t_srch = 25; t_mod = 35; t_rem = 90; end
      endcase
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) begin
        add_request(CMD_W'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST)),
                    4'($urandom), $urandom);
      end else begin
        if (r < t_ins) begin
          add_request(CMD_INSERT, 4'($urandom), pick_value());
        end else if (r < t_srch) begin
          v = ($urandom_range(0, 1) && used_vals.size() != 0) ?
              used_vals[$urandom_range(0, used_vals.size() - 1)] : pick_value();
          add_request(CMD_SEARCH, 4'($urandom), v);
        end else if (r < t_mod) begin
          add_request(CMD_MODIFY, 4'($urandom), pick_value());
        end else if (r < t_rem) begin
          add_request(CMD_REMOVE, 4'($urandom), $urandom);
        end else begin
          add_request(CMD_DUMP, 4'($urandom), $urandom, $urandom_range(0, 99) == 0);
        end
        n_cmds++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || has_item) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && reply_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
src/zmat_pkg.sv
src/zmat_front.sv
src/zmat_back.sv
src/zero_marked_array_table.sv
tb/zero_marked_array_table_test.sv
